// ===== design/bdfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfb_pkg: shared definitions of the box downscaler
// Screen geometry, field widths, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdfb_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_SCALE     = 16;

    localparam int COUNT_W    = 14;
    localparam int SCALE_W    = 5;
    localparam int CHAN_W     = 8;
    localparam int ACC_W      = 12;
    localparam int SUM_W      = 16;
    localparam int DIVISOR_W  = 9;
    localparam int COL_ADDR_W = 10;
    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int ADDR_W     = 19;
    localparam int ENTRY_W    = 3 * SUM_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;

    localparam int POS_DIV_STEPS = COUNT_W;
    localparam int SUM_DIV_STEPS = SUM_W;
    localparam int STEP_CNT_W    = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SCALE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_MODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd5;

    typedef struct packed {
        logic [SCALE_W-1:0] block_scale;
        logic [COUNT_W-1:0] source_width;
        logic [COUNT_W-1:0] source_height;
        logic               centre_mode;
        logic [X_W-1:0]     origin_x;
        logic [Y_W-1:0]     origin_y;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic update;
        logic merge;
        logic place;
        logic sdiv_init;
        logic sdiv_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic col_end;
        logic row_end;
        logic on_screen;
        logic out_busy;
    } status_t;

endpackage

// ===== design/box_downscale_to_framebuffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_to_framebuffer_core: box-filter downscaler for an 800x480 screen
// Averages square blocks of source pixels and emits framebuffer writes.
// ----------------------------------------------------------------------------
// Source pixels arrive one beat at a time in file row order, blue in the low
// byte of tdata, and tuser marks the first pixel of an image. Each channel is
// summed over block_scale by block_scale pixels (0 acts as 1, above 16 as 16),
// and every finished block that lands on the screen leaves as one beat carrying
// the truncated average and its framebuffer word address, with rows flipped
// bottom-up and the image either centered or put at the programmed origin. The
// block handles one pixel at a time: each pixel passes through the 14-step
// serial divider that turns the position into block coordinates, and a pixel
// that completes an on-screen block also through the 16-step divider that forms
// the average. A completed on-screen block also waits for as long as the
// previous beat is still held in the output register. A finished beat waits in
// the output register while the next pixel is taken. Registers must be
// written through the cfg channel only while the block is idle, which the block
// itself does not enforce; they act from the next pixel onward.
module box_downscale_to_framebuffer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bdfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bdfb_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Source pixel stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [23:0]                          s_axis_tdata,  // blue_in, green_in, red_in
    input  logic                                 s_axis_tuser,  // first_of_image
    // Framebuffer write stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [47:0]                          m_axis_tdata,  // pixel_rgb, fb_address, pad
    output logic                                 m_axis_tlast   // last_of_image
);
    import bdfb_pkg::*;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    logic                  ram_rd_en, ram_wr_en;
    logic [COL_ADDR_W-1:0] ram_rd_addr, ram_wr_addr;
    logic [ENTRY_W-1:0]    ram_rd_data, ram_wr_data;

    // The register file never stalls a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_scale   <= SCALE_W'(1);
            cfg_reg.source_width  <= COUNT_W'(SCREEN_WIDTH);
            cfg_reg.source_height <= COUNT_W'(SCREEN_HEIGHT);
            cfg_reg.centre_mode   <= 1'b1;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BLOCK_SCALE:   cfg_reg.block_scale   <= cfg_data[SCALE_W-1:0];
                REG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_data[COUNT_W-1:0];
                REG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_data[COUNT_W-1:0];
                REG_CENTRE_MODE:   cfg_reg.centre_mode   <= cfg_data[0];
                REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data[X_W-1:0];
                REG_ORIGIN_Y:      cfg_reg.origin_y      <= cfg_data[Y_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The controller sequences each pixel; the datapath does the arithmetic.
    bdfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdfb_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .cmd         (cmd),
        .status      (status),
        .pix_data    (s_axis_tdata),
        .pix_first   (s_axis_tuser),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

    // Per-column channel sums of the current band of source rows.
    bdfb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_band_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

`ifndef SYNTHESIS
    // Only one pixel is in work: ready drops right after a pixel is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel accepted while another is in work");

    // A result beat is only raised while a pixel is being worked on.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat raised with no pixel in work");

    // The band memory is never read and written in the same cycle.
    a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("band memory read and written together");
`endif

endmodule

// ===== design/bdfb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdfb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bdfb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfb_ctrl: sequencing controller
// Walks each accepted pixel through position division and accumulation, and on
// through band update, placement, averaging division and output as its block requires.
// ----------------------------------------------------------------------------
module bdfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bdfb_pkg::status_t status,
    output bdfb_pkg::cmd_t    cmd
);
    import bdfb_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MERGE,
        ST_PLACE,
        ST_DECIDE,
        ST_SDIV,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [STEP_CNT_W-1:0] step_cnt_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == ST_IDLE) && in_valid;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.update    = (state_reg == ST_CHECK);
        cmd.merge     = (state_reg == ST_MERGE);
        cmd.place     = (state_reg == ST_PLACE);
        cmd.sdiv_init = (state_reg == ST_DECIDE) && status.on_screen;
        cmd.sdiv_step = (state_reg == ST_SDIV);
        cmd.out_load  = (state_reg == ST_OUT) && !status.out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_cnt_reg == STEP_CNT_W'(POS_DIV_STEPS - 1))
                    begin
                        step_cnt_reg <= '0;
                        state_reg    <= ST_CHECK;
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                    end
                end
                ST_CHECK:
                begin
                    if (status.in_range && status.col_end)
                    begin
                        state_reg <= ST_MERGE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MERGE:
                begin
                    state_reg <= status.row_end ? ST_PLACE : ST_IDLE;
                end
                ST_PLACE:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    step_cnt_reg <= '0;
                    state_reg    <= status.on_screen ? ST_SDIV : ST_IDLE;
                end
                ST_SDIV:
                begin
                    if (step_cnt_reg == STEP_CNT_W'(SUM_DIV_STEPS - 1))
                    begin
                        step_cnt_reg <= '0;
                        state_reg    <= ST_OUT;
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/bdfb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdfb_dpath: downscaler datapath
// Position counters, bit-serial dividers, channel accumulators, placement
// arithmetic and the output register.
// ----------------------------------------------------------------------------
module bdfb_dpath (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  bdfb_pkg::cfg_t                            cfg,
    input  bdfb_pkg::cmd_t                            cmd,
    output bdfb_pkg::status_t                         status,
    input  logic [3*bdfb_pkg::CHAN_W-1:0]             pix_data,
    input  logic                                      pix_first,
    output logic                                      ram_rd_en,
    output logic [bdfb_pkg::COL_ADDR_W-1:0]           ram_rd_addr,
    input  logic [bdfb_pkg::ENTRY_W-1:0]              ram_rd_data,
    output logic                                      ram_wr_en,
    output logic [bdfb_pkg::COL_ADDR_W-1:0]           ram_wr_addr,
    output logic [bdfb_pkg::ENTRY_W-1:0]              ram_wr_data,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [47:0]                               out_data,
    output logic                                      out_last
);
    import bdfb_pkg::*;

    localparam int PDIV_W = SCALE_W + COUNT_W;
    localparam int SDIV_W = DIVISOR_W + SUM_W;

    // One restoring step: remainder in the upper bits, quotient shifting in.
    function automatic logic [PDIV_W-1:0] pos_step(input logic [PDIV_W-1:0] st,
                                                   input logic [SCALE_W-1:0] d);
        logic [SCALE_W:0] t;
        logic             qb;
        t = {st[PDIV_W-1:COUNT_W], st[COUNT_W-1]};
        if (t >= {1'b0, d})
        begin
            t  = t - {1'b0, d};
            qb = 1'b1;
        end
        else
        begin
            qb = 1'b0;
        end
        return {t[SCALE_W-1:0], st[COUNT_W-2:0], qb};
    endfunction

    function automatic logic [SDIV_W-1:0] sum_step(input logic [SDIV_W-1:0] st,
                                                   input logic [DIVISOR_W-1:0] d);
        logic [DIVISOR_W:0] t;
        logic               qb;
        t = {st[SDIV_W-1:SUM_W], st[SUM_W-1]};
        if (t >= {1'b0, d})
        begin
            t  = t - {1'b0, d};
            qb = 1'b1;
        end
        else
        begin
            qb = 1'b0;
        end
        return {t[DIVISOR_W-1:0], st[SUM_W-2:0], qb};
    endfunction

    logic [SCALE_W-1:0]   scale;
    logic [DIVISOR_W-1:0] scale_sq;

    logic [COUNT_W-1:0] col_reg, row_reg;
    logic [CHAN_W-1:0]  blue_reg, green_reg, red_reg;
    logic [ACC_W-1:0]   acc_b_reg, acc_g_reg, acc_r_reg;
    logic [SUM_W-1:0]   cell_b_reg, cell_g_reg, cell_r_reg;
    logic [PDIV_W-1:0]  col_div_reg, row_div_reg, wid_div_reg, hgt_div_reg;
    logic [SDIV_W-1:0]  b_div_reg, g_div_reg, r_div_reg;
    logic [X_W-1:0]     dcol_reg;
    logic [Y_W-1:0]     drow_reg;
    logic               on_screen_reg, last_reg;
    logic               out_valid_reg, out_last_reg;
    logic [47:0]        out_data_reg;

    logic [COUNT_W-1:0] col_eff, row_eff;
    logic [COUNT_W-1:0] bx, by, sw, sh;
    logic [SCALE_W-1:0] cx, cy;
    logic [COUNT_W:0]   col_inc;
    logic [SUM_W-1:0]   new_b, new_g, new_r;
    logic [X_W-1:0]     ox;
    logic [Y_W-1:0]     oy;
    logic [COUNT_W:0]   dcol_w, drow_w;
    logic [ADDR_W-1:0]  fb_addr;

    always_comb
    begin
        if (cfg.block_scale == '0)
        begin
            scale = SCALE_W'(1);
        end
        else if (cfg.block_scale > SCALE_W'(MAX_SCALE))
        begin
            scale = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            scale = cfg.block_scale;
        end
    end
    assign scale_sq = DIVISOR_W'(scale) * DIVISOR_W'(scale);

    assign col_eff = pix_first ? '0 : col_reg;
    assign row_eff = pix_first ? '0 : row_reg;

    assign bx = col_div_reg[COUNT_W-1:0];
    assign cx = col_div_reg[PDIV_W-1:COUNT_W];
    assign by = row_div_reg[COUNT_W-1:0];
    assign cy = row_div_reg[PDIV_W-1:COUNT_W];
    assign sw = wid_div_reg[COUNT_W-1:0];
    assign sh = hgt_div_reg[COUNT_W-1:0];

    assign status.in_range  = (bx < sw) && (by < sh) &&
                              ({1'b0, bx} < (COUNT_W + 1)'(MAX_OUT_WIDTH));
    assign status.col_end   = (cx == scale - 1'b1);
    assign status.row_end   = (cy == scale - 1'b1);
    assign status.on_screen = on_screen_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign col_inc = {1'b0, col_reg} + 1'b1;

    // Band entry: the first row of a block starts it, later rows add to it.
    always_comb
    begin
        if (cy == '0)
        begin
            new_r = SUM_W'(acc_r_reg);
            new_g = SUM_W'(acc_g_reg);
            new_b = SUM_W'(acc_b_reg);
        end
        else
        begin
            new_r = ram_rd_data[3*SUM_W-1:2*SUM_W] + SUM_W'(acc_r_reg);
            new_g = ram_rd_data[2*SUM_W-1:SUM_W] + SUM_W'(acc_g_reg);
            new_b = ram_rd_data[SUM_W-1:0] + SUM_W'(acc_b_reg);
        end
    end

    assign ram_rd_en   = cmd.update && status.in_range && status.col_end;
    assign ram_rd_addr = bx[COL_ADDR_W-1:0];
    assign ram_wr_en   = cmd.merge;
    assign ram_wr_addr = bx[COL_ADDR_W-1:0];
    assign ram_wr_data = {new_r, new_g, new_b};

    always_comb
    begin
        if (cfg.centre_mode)
        begin
            if (sw > COUNT_W'(SCREEN_WIDTH))
            begin
                ox = '0;
            end
            else
            begin
                ox = X_W'((COUNT_W'(SCREEN_WIDTH) - sw) >> 1);
            end
            if (sh > COUNT_W'(SCREEN_HEIGHT))
            begin
                oy = '0;
            end
            else
            begin
                oy = Y_W'((COUNT_W'(SCREEN_HEIGHT) - sh) >> 1);
            end
        end
        else
        begin
            ox = cfg.origin_x;
            oy = cfg.origin_y;
        end
    end

    assign dcol_w  = (COUNT_W + 1)'(ox) + (COUNT_W + 1)'(bx);
    assign drow_w  = (COUNT_W + 1)'(oy) + (COUNT_W + 1)'(sh) - 1'b1 - (COUNT_W + 1)'(by);
    assign fb_addr = ADDR_W'(drow_reg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(dcol_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            acc_b_reg     <= '0;
            acc_g_reg     <= '0;
            acc_r_reg     <= '0;
            on_screen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                col_reg <= col_eff;
                row_reg <= row_eff;
            end
            if (cmd.update)
            begin
                if (status.in_range)
                begin
                    if (cx == '0)
                    begin
                        acc_r_reg <= ACC_W'(red_reg);
                        acc_g_reg <= ACC_W'(green_reg);
                        acc_b_reg <= ACC_W'(blue_reg);
                    end
                    else
                    begin
                        acc_r_reg <= acc_r_reg + ACC_W'(red_reg);
                        acc_g_reg <= acc_g_reg + ACC_W'(green_reg);
                        acc_b_reg <= acc_b_reg + ACC_W'(blue_reg);
                    end
                end
                if (col_inc >= {1'b0, cfg.source_width})
                begin
                    col_reg <= '0;
                    if (row_reg < COUNT_MAX)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_inc[COUNT_W-1:0];
                end
            end
            if (cmd.place)
            begin
                on_screen_reg <= (dcol_w < (COUNT_W + 1)'(SCREEN_WIDTH)) &&
                                 (drow_w < (COUNT_W + 1)'(SCREEN_HEIGHT));
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            blue_reg    <= pix_data[CHAN_W-1:0];
            green_reg   <= pix_data[2*CHAN_W-1:CHAN_W];
            red_reg     <= pix_data[3*CHAN_W-1:2*CHAN_W];
            col_div_reg <= {{SCALE_W{1'b0}}, col_eff};
            row_div_reg <= {{SCALE_W{1'b0}}, row_eff};
            wid_div_reg <= {{SCALE_W{1'b0}}, cfg.source_width};
            hgt_div_reg <= {{SCALE_W{1'b0}}, cfg.source_height};
        end
        if (cmd.div_step)
        begin
            col_div_reg <= pos_step(col_div_reg, scale);
            row_div_reg <= pos_step(row_div_reg, scale);
            wid_div_reg <= pos_step(wid_div_reg, scale);
            hgt_div_reg <= pos_step(hgt_div_reg, scale);
        end
        if (cmd.merge)
        begin
            cell_r_reg <= new_r;
            cell_g_reg <= new_g;
            cell_b_reg <= new_b;
        end
        if (cmd.place)
        begin
            dcol_reg <= dcol_w[X_W-1:0];
            drow_reg <= drow_w[Y_W-1:0];
            last_reg <= (bx == sw - 1'b1) && (by == sh - 1'b1);
        end
        if (cmd.sdiv_init)
        begin
            r_div_reg <= {{DIVISOR_W{1'b0}}, cell_r_reg};
            g_div_reg <= {{DIVISOR_W{1'b0}}, cell_g_reg};
            b_div_reg <= {{DIVISOR_W{1'b0}}, cell_b_reg};
        end
        if (cmd.sdiv_step)
        begin
            r_div_reg <= sum_step(r_div_reg, scale_sq);
            g_div_reg <= sum_step(g_div_reg, scale_sq);
            b_div_reg <= sum_step(b_div_reg, scale_sq);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {5'b0, fb_addr, r_div_reg[CHAN_W-1:0],
                             g_div_reg[CHAN_W-1:0], b_div_reg[CHAN_W-1:0]};
            out_last_reg <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sim/box_downscale_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_checker: scoreboard for the box downscaler
// Watches the register, pixel and framebuffer channels, averages blocks on
// its own and compares every framebuffer beat with the oldest expected one.
// ----------------------------------------------------------------------------
module box_downscale_checker
    import bdfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [23:0]            s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [47:0]            m_axis_tdata,
    input  logic                   m_axis_tlast,
    output int                     mismatches,
    output int                     pending
);

    typedef struct {
        logic [23:0]       rgb;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } fb_write_t;

    fb_write_t fb_writes_due[$];

    logic [SCALE_W-1:0] scale_reg;
    logic [COUNT_W-1:0] width_reg;
    logic [COUNT_W-1:0] height_reg;
    logic               centre_reg;
    logic [X_W-1:0]     org_x_reg;
    logic [Y_W-1:0]     org_y_reg;

    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned run_r, run_g, run_b;
    int unsigned band_r [MAX_OUT_WIDTH];
    int unsigned band_g [MAX_OUT_WIDTH];
    int unsigned band_b [MAX_OUT_WIDTH];

    assign pending = fb_writes_due.size();

    task automatic step_position();
        if (col_pos + 1 >= width_reg) begin
            col_pos = 0;
            if (row_pos < COUNT_MAX) row_pos++;
        end
        else begin
            col_pos++;
        end
    endtask

    // Accumulate one source pixel and queue a framebuffer write when it
    // completes an on-screen block.
    task automatic average_pixel(logic [23:0] px, logic first);
        int unsigned s, sw, sh, bx, by, cx, cy, sq;
        int ox, oy, dcol, drow;
        fb_write_t w;
        if (first) begin
            col_pos = 0;
            row_pos = 0;
        end
        s = scale_reg;
        if (s == 0) s = 1;
        if (s > MAX_SCALE) s = MAX_SCALE;
        sw = width_reg / s;
        sh = height_reg / s;
        bx = col_pos / s;
        cx = col_pos % s;
        by = row_pos / s;
        cy = row_pos % s;
        if (bx >= sw || by >= sh || bx >= MAX_OUT_WIDTH) begin
            step_position();
            return;
        end
        if (cx == 0) begin
            run_r = 0;
            run_g = 0;
            run_b = 0;
        end
        run_b += px[7:0];
        run_g += px[15:8];
        run_r += px[23:16];
        step_position();
        if (cx != s - 1) return;
        if (cy == 0) begin
            band_r[bx] = run_r;
            band_g[bx] = run_g;
            band_b[bx] = run_b;
        end
        else begin
            band_r[bx] += run_r;
            band_g[bx] += run_g;
            band_b[bx] += run_b;
        end
        if (cy != s - 1) return;
        if (centre_reg) begin
            ox = (sw > SCREEN_WIDTH) ? 0 : (SCREEN_WIDTH - int'(sw)) / 2;
            oy = (sh > SCREEN_HEIGHT) ? 0 : (SCREEN_HEIGHT - int'(sh)) / 2;
        end
        else begin
            ox = org_x_reg;
            oy = org_y_reg;
        end
        dcol = ox + int'(bx);
        drow = oy + int'(sh) - 1 - int'(by);
        if (dcol < 0 || dcol >= SCREEN_WIDTH || drow < 0 || drow >= SCREEN_HEIGHT) return;
        sq = s * s;
        w.rgb  = {8'(band_r[bx] / sq), 8'(band_g[bx] / sq), 8'(band_b[bx] / sq)};
        w.addr = ADDR_W'(drow * SCREEN_WIDTH + dcol);
        w.last = (bx == sw - 1 && by == sh - 1);
        fb_writes_due.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n) begin
        fb_write_t w;
        if (!rst_n) begin
            scale_reg  <= 5'd1;
            width_reg  <= 14'd800;
            height_reg <= 14'd480;
            centre_reg <= 1'b1;
            org_x_reg  <= '0;
            org_y_reg  <= '0;
            col_pos    = 0;
            row_pos    = 0;
            run_r      = 0;
            run_g      = 0;
            run_b      = 0;
            mismatches <= 0;
            fb_writes_due.delete();
        end
        else begin
            // The framebuffer beat is checked first; a pixel taken in the same
            // cycle can only add to the back of the queue.
            if (m_axis_tvalid && m_axis_tready) begin
                if (fb_writes_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: framebuffer beat with nothing due: rgb %h addr %0d",
                                 $realtime, m_axis_tdata[23:0], m_axis_tdata[42:24]);
                    mismatches <= mismatches + 1;
                end
                else begin
                    w = fb_writes_due.pop_front();
                    if (m_axis_tdata[23:0] !== w.rgb || m_axis_tdata[42:24] !== w.addr ||
                        m_axis_tlast !== w.last) begin
                        if (mismatches < 10)
                            $display("%0t: expected rgb %h addr %0d last %b, got %h %0d %b",
                                     $realtime, w.rgb, w.addr, w.last, m_axis_tdata[23:0],
                                     m_axis_tdata[42:24], m_axis_tlast);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                average_pixel(s_axis_tdata, s_axis_tuser);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BLOCK_SCALE:   scale_reg  <= cfg_data[SCALE_W-1:0];
                    REG_SOURCE_WIDTH:  width_reg  <= cfg_data[COUNT_W-1:0];
                    REG_SOURCE_HEIGHT: height_reg <= cfg_data[COUNT_W-1:0];
                    REG_CENTRE_MODE:   centre_reg <= cfg_data[0];
                    REG_ORIGIN_X:      org_x_reg  <= cfg_data[X_W-1:0];
                    REG_ORIGIN_Y:      org_y_reg  <= cfg_data[Y_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/tb_box_downscale_to_framebuffer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_downscale_to_framebuffer_core: stimulus and verdict for the downscaler
// Streams small images under many register settings and idle patterns while
// a checker module predicts and compares every framebuffer beat.
// ----------------------------------------------------------------------------
module tb_box_downscale_to_framebuffer_core;
    import bdfb_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata;   // blue_in, green_in, red_in
    logic                   s_axis_tuser;   // first_of_image
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [47:0]            m_axis_tdata;   // pixel_rgb, fb_address, pad
    logic                   m_axis_tlast;   // last_of_image

    int mismatches;
    int pending;
    int pixels_sent;
    int src_idle_pct;
    int sink_stall_pct;

    box_downscale_to_framebuffer_core dut (.*);

    box_downscale_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // The framebuffer side stalls at random in the current idle phase.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Idle phases rotate every 150 pixels: none, sender idle, receiver
    // stalling, and both together.
    task automatic pick_phase();
        case ((pixels_sent / 150) % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
            default: begin src_idle_pct = 31; sink_stall_pct = 31; end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the beat,
    // leaving tvalid to the next pixel or to settle().
    task automatic send_pixel(logic [23:0] px, logic first);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= first;
        #1;
        while (!s_axis_tready)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
        pixels_sent++;
        pick_phase();
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        #1;
        while (!cfg_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
    endtask

    // Wait until every expected beat has left and a pixel that gave no beat
    // has certainly finished inside the block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic program_all(int unsigned scale, int unsigned w, int unsigned h,
                               int unsigned centre, int unsigned ox, int unsigned oy);
        settle();
        write_reg(REG_BLOCK_SCALE, scale);
        write_reg(REG_SOURCE_WIDTH, w);
        write_reg(REG_SOURCE_HEIGHT, h);
        write_reg(REG_CENTRE_MODE, centre);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        cfg_valid <= 1'b0;
    endtask

    // Sends count random pixels, the first one opening a new image.
    task automatic send_image(int count);
        for (int i = 0; i < count; i++)
            send_pixel(24'($urandom), i == 0);
    endtask

    initial
    begin
        int unsigned scale, eff, w, h, ox, oy, count;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        pixels_sent   = 0;
        pick_phase();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Scale one, centered, with all-zero and all-one pixels.
        program_all(1, 2, 2, 1, 0, 0);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        // Scale zero acts as one; a stray pixel past the image gives nothing.
        program_all(0, 3, 1, 1, 0, 0);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h81C3E7, 1'b0);
        send_pixel(24'h123456, 1'b0);
        // Scale two at the far corner of the screen: half the blocks fall off it,
        // and the dropped right column and bottom row are exercised.
        program_all(2, 5, 5, 0, 799, 478);
        send_image(25);
        // Centering a source wider than the screen puts the left edge at 0.
        program_all(1, 16383, 1, 1, 0, 0);
        send_image(4);
        // Centering a source taller than the screen: the rows land off screen.
        program_all(1, 1, 16383, 1, 0, 0);
        send_image(3);

        // Random images, mostly well formed, some cut short or overrun, until
        // about 800 pixels have gone in.
        while (pixels_sent < 800)
        begin
            case ($urandom_range(9))
                0: scale = 0;
                1: scale = $urandom_range(16, 31);
                2: scale = $urandom_range(5, 8);
                default: scale = $urandom_range(1, 4);
            endcase
            eff = (scale == 0) ? 1 : (scale > 16 ? 16 : scale);
            if (eff > 8)
            begin
                w = eff + $urandom_range(eff - 1);
                h = eff;
            end
            else
            begin
                w = eff * $urandom_range(1, 5) + $urandom_range(eff - 1);
                h = eff * $urandom_range(1, 4) + $urandom_range(eff - 1);
            end
            if ($urandom_range(9) == 0) w = $urandom_range(790, 830);
            if ($urandom_range(9) < 3)
            begin
                ox = $urandom_range(795, 799);
                oy = $urandom_range(0, 2);
            end
            else
            begin
                ox = $urandom_range(1023);
                oy = $urandom_range(511);
            end
            program_all(scale, w, (w > 700) ? 1 : h, $urandom_range(1), ox, oy);
            count = (w > 700) ? w : w * h;
            case ($urandom_range(9))
                0: count = $urandom_range(1, count);
                1: count = count + $urandom_range(1, 3);
                default: ;
            endcase
            // The last image is cut to keep the total near the budget.
            if (count > 820 - pixels_sent) count = 820 - pixels_sent;
            send_image(count);
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("[box_downscale_to_framebuffer_core] OK");
        else
            $display("[box_downscale_to_framebuffer_core] ERROR");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("[box_downscale_to_framebuffer_core] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/bdfb_pkg.sv
design/bdfb_ram.sv
design/bdfb_ctrl.sv
design/bdfb_dpath.sv
design/box_downscale_to_framebuffer_core.sv
sim/box_downscale_checker.sv
sim/tb_box_downscale_to_framebuffer_core.sv
